[hw/rtl/rhsl_pkg.sv]
// Shared constants and types for the RGB to HSL converter.
`default_nettype none

package rhsl_pkg;

    // Headroom above 2*CHANNEL_BITS for the rounded dividends.
    localparam int unsigned NUM_EXT_BITS = 4;
    // Headroom above CHANNEL_BITS for the hue divisor (12 * chroma).
    localparam int unsigned HDIV_EXT_BITS = 4;
    // Headroom above CHANNEL_BITS for the saturation divisor (2 * D).
    localparam int unsigned SDIV_EXT_BITS = 2;

    // Which channel holds the maximum.
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

endpackage

`default_nettype wire

[hw/rtl/rhsl_front.sv]
// Front end: sorts the channels and forms dividends and divisors.
`default_nettype none

module rhsl_front #(
    parameter int unsigned CHANNEL_BITS = 8
) (
    input  wire logic [CHANNEL_BITS-1:0] red,
    input  wire logic [CHANNEL_BITS-1:0] green,
    input  wire logic [CHANNEL_BITS-1:0] blue,
    output logic [2*CHANNEL_BITS+rhsl_pkg::NUM_EXT_BITS-1:0] hue_num,
    output logic [CHANNEL_BITS+rhsl_pkg::HDIV_EXT_BITS-1:0]  hue_den,
    output logic [2*CHANNEL_BITS+rhsl_pkg::NUM_EXT_BITS-1:0] sat_num,
    output logic [CHANNEL_BITS+rhsl_pkg::SDIV_EXT_BITS-1:0]  sat_den,
    output logic                                             grey,
    output logic [CHANNEL_BITS-1:0]                          lightness
);
    import rhsl_pkg::*;

    localparam int unsigned CB  = CHANNEL_BITS;
    localparam int unsigned W   = 2 * CB + NUM_EXT_BITS;
    localparam int unsigned NW  = CB + 3;
    localparam int unsigned HYW = CB + HDIV_EXT_BITS;
    localparam int unsigned SYW = CB + SDIV_EXT_BITS;
    localparam logic [CB:0] FULL = {1'b0, {CB{1'b1}}};

    logic [CB-1:0] mx;
    logic [CB-1:0] mn;
    logic [CB-1:0] chroma;
    logic [CB:0]   sum;
    logic [CB:0]   dev;
    logic [CB:0]   den_d;
    logic [CB+1:0] sum_rnd;
    logic [NW-1:0] c_n;
    logic [NW-1:0] six_c;
    logic [NW-1:0] n;
    logic [W-1:0]  n_w;
    logic [W-1:0]  c_w;
    sector_t       sector;

    always_comb
    begin
        mx = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
    end

    assign chroma = mx - mn;
    assign sum    = {1'b0, mx} + {1'b0, mn};
    assign grey   = (chroma == '0);

    // lightness = floor((M + m + 1) / 2)
    assign sum_rnd   = {1'b0, sum} + (CB+2)'(1);
    assign lightness = sum_rnd[CB:1];

    // Ties: red first, then green.
    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            sector = SEC_RED;
        end
        else if (green >= blue)
        begin
            sector = SEC_GREEN;
        end
        else
        begin
            sector = SEC_BLUE;
        end
    end

    assign c_n   = NW'(chroma);
    assign six_c = (c_n << 2) + (c_n << 1);

    // Hue numerator in sixths of a turn, in [0, 6C) whenever the chroma C is non-zero.
    always_comb
    begin
        unique case (sector)
            SEC_RED:
            begin
                if (green >= blue)
                begin
                    n = NW'(green) - NW'(blue);
                end
                else
                begin
                    n = six_c - (NW'(blue) - NW'(green));
                end
            end
            SEC_GREEN: n = (c_n << 1) + NW'(blue) - NW'(red);
            SEC_BLUE:  n = (c_n << 2) + NW'(red) - NW'(green);
            default:   n = '0;
        endcase
    end

    // F * x is (x << CB) - x; round half up: (2*num + den) / (2*den).
    assign n_w     = W'(n);
    assign c_w     = W'(chroma);
    assign hue_num = (((n_w << CB) - n_w) << 1) + W'(six_c);
    assign hue_den = (HYW'(chroma) << 3) + (HYW'(chroma) << 2);

    assign dev     = (sum >= FULL) ? (sum - FULL) : (FULL - sum);
    assign den_d   = FULL - dev;
    assign sat_num = (((c_w << CB) - c_w) << 1) + W'(den_d);
    assign sat_den = SYW'(den_d) << 1;

endmodule

`default_nettype wire

[hw/rtl/rhsl_fifo.sv]
// Small register queue between the front end and the divider pipeline.
`default_nettype none

module rhsl_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_stall,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_take,
    output logic [WIDTH-1:0]      rd_data
);
    import rhsl_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             push;
    logic             pop;

    assign wr_stall = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_take && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rhsl_back.sv]
// Back end: two restoring dividers, one quotient bit per stage, and output register.
`default_nettype none

module rhsl_back #(
    parameter int unsigned CHANNEL_BITS = 8
) (
    input  wire logic                                             clk,
    input  wire logic                                             rst_n,
    input  wire logic                                             q_valid,
    output logic                                                  q_take,
    input  wire logic [2*CHANNEL_BITS+rhsl_pkg::NUM_EXT_BITS-1:0] q_hue_num,
    input  wire logic [CHANNEL_BITS+rhsl_pkg::HDIV_EXT_BITS-1:0]  q_hue_den,
    input  wire logic [2*CHANNEL_BITS+rhsl_pkg::NUM_EXT_BITS-1:0] q_sat_num,
    input  wire logic [CHANNEL_BITS+rhsl_pkg::SDIV_EXT_BITS-1:0]  q_sat_den,
    input  wire logic                                             q_grey,
    input  wire logic [CHANNEL_BITS-1:0]                          q_lightness,
    output logic                                                  hsl_valid,
    input  wire logic                                             hsl_stall,
    output logic [CHANNEL_BITS-1:0]                               hue,
    output logic [CHANNEL_BITS-1:0]                               saturation,
    output logic [CHANNEL_BITS-1:0]                               lightness
);
    import rhsl_pkg::*;

    localparam int unsigned CB  = CHANNEL_BITS;
    localparam int unsigned W   = 2 * CB + NUM_EXT_BITS;
    localparam int unsigned HYW = CB + HDIV_EXT_BITS;
    localparam int unsigned SYW = CB + SDIV_EXT_BITS;

    // Stage i settles quotient bit CB-1-i.
    logic [CB-1:0]  vld_reg;
    logic [W-1:0]   hrem_reg  [CB];
    logic [W-1:0]   hrem_next [CB];
    logic [HYW-1:0] hden_reg  [CB];
    logic [HYW-1:0] hden_next [CB];
    logic [CB-1:0]  hq_reg    [CB];
    logic [CB-1:0]  hq_next   [CB];
    logic [W-1:0]   srem_reg  [CB];
    logic [W-1:0]   srem_next [CB];
    logic [SYW-1:0] sden_reg  [CB];
    logic [SYW-1:0] sden_next [CB];
    logic [CB-1:0]  sq_reg    [CB];
    logic [CB-1:0]  sq_next   [CB];
    logic [CB-1:0]  grey_reg;
    logic [CB-1:0]  grey_next;
    logic [CB-1:0]  lig_reg   [CB];
    logic [CB-1:0]  lig_next  [CB];

    logic           hsl_valid_reg;
    logic [CB-1:0]  hue_reg;
    logic [CB-1:0]  sat_reg;
    logic [CB-1:0]  lig_out_reg;
    logic           advance;

    // Whole pipeline moves together unless the output word is held.
    assign advance = !hsl_valid_reg || !hsl_stall;
    assign q_take  = advance && q_valid;

    always_comb
    begin
        logic [W-1:0]   hr;
        logic [HYW-1:0] hy;
        logic [CB-1:0]  hq;
        logic [W-1:0]   sr;
        logic [SYW-1:0] sy;
        logic [CB-1:0]  sq;
        logic [W-1:0]   hsh;
        logic [W-1:0]   ssh;
        for (int i = 0; i < CB; i++)
        begin
            if (i == 0)
            begin
                hr           = q_hue_num;
                hy           = q_hue_den;
                hq           = '0;
                sr           = q_sat_num;
                sy           = q_sat_den;
                sq           = '0;
                grey_next[i] = q_grey;
                lig_next[i]  = q_lightness;
            end
            else
            begin
                hr           = hrem_reg[i-1];
                hy           = hden_reg[i-1];
                hq           = hq_reg[i-1];
                sr           = srem_reg[i-1];
                sy           = sden_reg[i-1];
                sq           = sq_reg[i-1];
                grey_next[i] = grey_reg[i-1];
                lig_next[i]  = lig_reg[i-1];
            end
            hsh = W'(hy) << (CB - 1 - i);
            ssh = W'(sy) << (CB - 1 - i);
            if (hr >= hsh)
            begin
                hrem_next[i] = hr - hsh;
                hq_next[i]   = {hq[CB-2:0], 1'b1};
            end
            else
            begin
                hrem_next[i] = hr;
                hq_next[i]   = {hq[CB-2:0], 1'b0};
            end
            if (sr >= ssh)
            begin
                srem_next[i] = sr - ssh;
                sq_next[i]   = {sq[CB-2:0], 1'b1};
            end
            else
            begin
                srem_next[i] = sr;
                sq_next[i]   = {sq[CB-2:0], 1'b0};
            end
            hden_next[i] = hy;
            sden_next[i] = sy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            hsl_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg       <= {vld_reg[CB-2:0], q_valid};
            hsl_valid_reg <= vld_reg[CB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < CB; i++)
            begin
                hrem_reg[i] <= hrem_next[i];
                hden_reg[i] <= hden_next[i];
                hq_reg[i]   <= hq_next[i];
                srem_reg[i] <= srem_next[i];
                sden_reg[i] <= sden_next[i];
                sq_reg[i]   <= sq_next[i];
                lig_reg[i]  <= lig_next[i];
            end
            grey_reg    <= grey_next;
            // Grey pixel: hue and saturation forced to zero.
            hue_reg     <= grey_reg[CB-1] ? '0 : hq_reg[CB-1];
            sat_reg     <= grey_reg[CB-1] ? '0 : sq_reg[CB-1];
            lig_out_reg <= lig_reg[CB-1];
        end
    end

    assign hsl_valid  = hsl_valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = lig_out_reg;

endmodule

`default_nettype wire

[hw/rtl/rgb_to_hsl_converter_top.sv]
// Top level of the RGB to HSL pixel converter.
// A pixel passes through the queue, the divider stages and the output register in turn.
// Throughput: one pixel per cycle unless the output is held; one quotient bit per stage.
// A QUEUE_DEPTH-word queue takes up to that many pixels while the output is stalled.
// Reset (rst_n low, asynchronous) empties the queue and the pipeline; no clearing pass.
// No configuration registers; the datapath holds no state between pixels.
`default_nettype none

module rgb_to_hsl_converter_top #(
    parameter int unsigned CHANNEL_BITS = 8,
    parameter int unsigned QUEUE_DEPTH  = 2
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    pix_valid,
    output logic                         pix_stall,
    input  wire logic [CHANNEL_BITS-1:0] red,
    input  wire logic [CHANNEL_BITS-1:0] green,
    input  wire logic [CHANNEL_BITS-1:0] blue,
    output logic                         hsl_valid,
    input  wire logic                    hsl_stall,
    output logic [CHANNEL_BITS-1:0]      hue,
    output logic [CHANNEL_BITS-1:0]      saturation,
    output logic [CHANNEL_BITS-1:0]      lightness
);
    import rhsl_pkg::*;

    localparam int unsigned CB  = CHANNEL_BITS;
    localparam int unsigned W   = 2 * CB + NUM_EXT_BITS;
    localparam int unsigned HYW = CB + HDIV_EXT_BITS;
    localparam int unsigned SYW = CB + SDIV_EXT_BITS;
    // Queue word: hue num, hue den, sat num, sat den, grey flag, lightness.
    localparam int unsigned QW  = W + HYW + W + SYW + 1 + CB;

    logic [W-1:0]   f_hue_num;
    logic [HYW-1:0] f_hue_den;
    logic [W-1:0]   f_sat_num;
    logic [SYW-1:0] f_sat_den;
    logic           f_grey;
    logic [CB-1:0]  f_lightness;

    logic [W-1:0]   b_hue_num;
    logic [HYW-1:0] b_hue_den;
    logic [W-1:0]   b_sat_num;
    logic [SYW-1:0] b_sat_den;
    logic           b_grey;
    logic [CB-1:0]  b_lightness;

    logic [QW-1:0]  q_wr_data;
    logic [QW-1:0]  q_rd_data;
    logic           q_rd_valid;
    logic           q_take;

    // Front end: max/min sort, sector pick and the scaled rounding dividends.
    // Purely combinational; its results are captured straight into the queue.
    rhsl_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .red       (red),
        .green     (green),
        .blue      (blue),
        .hue_num   (f_hue_num),
        .hue_den   (f_hue_den),
        .sat_num   (f_sat_num),
        .sat_den   (f_sat_den),
        .grey      (f_grey),
        .lightness (f_lightness)
    );

    assign q_wr_data = {f_hue_num, f_hue_den, f_sat_num, f_sat_den, f_grey, f_lightness};

    // Decoupling queue: the pixel side is stalled only when it is full.
    rhsl_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (pix_valid),
        .wr_stall (pix_stall),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_take  (q_take),
        .rd_data  (q_rd_data)
    );

    assign {b_hue_num, b_hue_den, b_sat_num, b_sat_den, b_grey, b_lightness} = q_rd_data;

    // Back end: CHANNEL_BITS restoring-division stages for hue and saturation,
    // followed by the output word register.
    rhsl_back #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_rd_valid),
        .q_take      (q_take),
        .q_hue_num   (b_hue_num),
        .q_hue_den   (b_hue_den),
        .q_sat_num   (b_sat_num),
        .q_sat_den   (b_sat_den),
        .q_grey      (b_grey),
        .q_lightness (b_lightness),
        .hsl_valid   (hsl_valid),
        .hsl_stall   (hsl_stall),
        .hue         (hue),
        .saturation  (saturation),
        .lightness   (lightness)
    );

endmodule

`default_nettype wire

[hw/rtl/rhsl_checker.sv]
// Port-level checks for the RGB to HSL converter, bound to the top level.
`default_nettype none

module rhsl_checker #(
    parameter int unsigned CHANNEL_BITS = 8
) (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    pix_valid,
    input wire logic                    pix_stall,
    input wire logic [CHANNEL_BITS-1:0] red,
    input wire logic [CHANNEL_BITS-1:0] green,
    input wire logic [CHANNEL_BITS-1:0] blue,
    input wire logic                    hsl_valid,
    input wire logic                    hsl_stall,
    input wire logic [CHANNEL_BITS-1:0] hue,
    input wire logic [CHANNEL_BITS-1:0] saturation,
    input wire logic [CHANNEL_BITS-1:0] lightness
);
    import rhsl_pkg::*;

    // Held output word stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && hsl_stall |=> hsl_valid && $stable(hue) && $stable(saturation)
            && $stable(lightness))
        else $error("held HSL word changed");

    // Non-zero chroma always gives non-zero saturation, so zero saturation means grey.
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && saturation == '0 |-> hue == '0)
        else $error("grey word with non-zero hue");

    // Nothing leaves the block while reset is held.
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !hsl_valid)
        else $error("HSL word valid during reset");

    // The queue cannot fill up without an incoming pixel word.
    a_queue: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_valid && !$past(pix_valid) && $past(rst_n) && !$past(hsl_valid) && !hsl_valid
            |=> !pix_stall || $past(pix_stall))
        else $error("queue filled without input");

endmodule

bind rgb_to_hsl_converter_top rhsl_checker #(
    .CHANNEL_BITS (CHANNEL_BITS)
) u_rhsl_checker (.*);

`default_nettype wire

[tb/sv/hsl_checker.sv]
// Checker for the RGB to HSL converter: watches both channels, predicts and compares.
module hsl_checker #(
    parameter int unsigned CHANNEL_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pix_valid,
    input  logic                    pix_stall,
    input  logic [CHANNEL_BITS-1:0] red,
    input  logic [CHANNEL_BITS-1:0] green,
    input  logic [CHANNEL_BITS-1:0] blue,
    input  logic                    hsl_valid,
    input  logic                    hsl_stall,
    input  logic [CHANNEL_BITS-1:0] hue,
    input  logic [CHANNEL_BITS-1:0] saturation,
    input  logic [CHANNEL_BITS-1:0] lightness,
    output int                      mismatches,
    output int                      outstanding,
    output int                      checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import rhsl_pkg::*;

    typedef logic [CHANNEL_BITS-1:0] chan_t;

    typedef struct packed {
        chan_t hue;
        chan_t sat;
        chan_t lig;
    } hsl_word_t;

    hsl_word_t hsl_due[$];

    // Exact integer conversion, rounding half up throughout.
    function automatic hsl_word_t predict_hsl(input chan_t r_in, input chan_t g_in,
                                              input chan_t b_in);
        longint unsigned f, r, g, b, mx, mn, c, sum, dev, den, n, h, s;
        sector_t sec;
        hsl_word_t w;
        f = (64'd1 << CHANNEL_BITS) - 1;
        r = r_in;
        g = g_in;
        b = b_in;
        if (r >= g && r >= b)
            sec = SEC_RED;
        else if (g >= b)
            sec = SEC_GREEN;
        else
            sec = SEC_BLUE;
        case (sec)
            SEC_RED:   mx = r;
            SEC_GREEN: mx = g;
            default:   mx = b;
        endcase
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        c = mx - mn;
        sum = mx + mn;
        w.lig = chan_t'((sum + 1) >> 1);
        if (c == 0) begin
            w.hue = '0;
            w.sat = '0;
        end else begin
            case (sec)
                SEC_RED:   n = (g >= b) ? (g - b) : (6 * c - (b - g));
                SEC_GREEN: n = 2 * c + b - r;
                default:   n = 4 * c + r - g;
            endcase
            // Red-sector hue just short of a full turn may reach F; kept, not wrapped.
            h = (2 * f * n + 6 * c) / (12 * c);
            if (h > f) h = f;
            dev = (sum >= f) ? (sum - f) : (f - sum);
            den = f - dev;
            if (den == 0)
                s = f;
            else begin
                s = (2 * f * c + den) / (2 * den);
                if (s > f) s = f;
            end
            w.hue = chan_t'(h);
            w.sat = chan_t'(s);
        end
        return w;
    endfunction

    always @(posedge clk) begin
        hsl_word_t want;
        if (!rst_n) begin
            mismatches  <= 0;
            outstanding <= 0;
            checked     <= 0;
            hsl_due.delete();
        end else begin
            if (hsl_valid && !hsl_stall) begin
                checked <= checked + 1;
                if (hsl_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected HSL word h=%0d s=%0d l=%0d",
                                 $realtime, hue, saturation, lightness);
                    mismatches <= mismatches + 1;
                end else begin
                    want = hsl_due.pop_front();
                    if (hue !== want.hue || saturation !== want.sat ||
                        lightness !== want.lig) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch: exp h=%0d s=%0d l=%0d, got h=%0d s=%0d l=%0d",
                                     $realtime, want.hue, want.sat, want.lig,
                                     hue, saturation, lightness);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (pix_valid && !pix_stall)
                hsl_due.push_back(predict_hsl(red, green, blue));
            outstanding <= hsl_due.size();
        end
    end

endmodule

[tb/sv/tb.sv]
// Testbench top for the RGB to HSL converter: clock, reset, pixel stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CB = 8;
    localparam logic [CB-1:0] FS = '1;   // full scale
    localparam int RANDOM_PER_PHASE = 175;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 24;     // pipeline is CB + 1 deep, plus margin

    logic          clk        = 1'b0;
    logic          rst_n      = 1'b0;
    logic          pix_valid  = 1'b0;
    logic          hsl_stall  = 1'b0;
    logic [CB-1:0] red        = '0;
    logic [CB-1:0] green      = '0;
    logic [CB-1:0] blue       = '0;
    logic          pix_stall;
    logic          hsl_valid;
    logic [CB-1:0] hue;
    logic [CB-1:0] saturation;
    logic [CB-1:0] lightness;

    int mismatches;
    int outstanding;
    int checked;

    // Idle and stall odds, in percent, changed per phase.
    int idle_pct  = 0;
    int stall_pct = 0;
    int pixels_sent = 0;
    int cycles = 0;

    rgb_to_hsl_converter_top #(
        .CHANNEL_BITS(CB)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .hsl_valid  (hsl_valid),
        .hsl_stall  (hsl_stall),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness)
    );

    hsl_checker #(
        .CHANNEL_BITS(CB)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .hsl_valid   (hsl_valid),
        .hsl_stall   (hsl_stall),
        .hue         (hue),
        .saturation  (saturation),
        .lightness   (lightness),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        cycles <= cycles + 1;

    // Receiver back-pressure; a fresh draw every cycle so stalls hit every pipeline phase.
    always @(posedge clk)
        hsl_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d words still due", cycles, outstanding);
        $display("tb NOT OK");
        $finish;
    end

    // Offer one pixel word and hold it until the converter takes it.
    // Leaves pix_valid high so back-to-back words need no extra assignment.
    task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                              input logic [CB-1:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        red       <= r;
        green     <= g;
        blue      <= b;
        do
            @(posedge clk);
        while (pix_stall);
        pixels_sent++;
    endtask

    // Sender pauses until every predicted word has come back.
    task automatic drain;
        pix_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic [CB-1:0] pick_level;
        case ($urandom_range(2))
            0:       return '0;
            1:       return FS;
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic logic [CB-1:0] nudge(input logic [CB-1:0] v);
        int t;
        t = int'(v) + $urandom_range(4) - 2;
        if (t < 0) t = 0;
        if (t > int'(FS)) t = int'(FS);
        return CB'(t);
    endfunction

    // Random pixel, biased towards greys, ties and the rails where the arithmetic is touchy.
    task automatic send_random_pixel;
        logic [CB-1:0] a, b, c;
        a = CB'($urandom);
        b = CB'($urandom);
        c = CB'($urandom);
        case ($urandom_range(9))
            5:       send_pixel(a, a, a);                     // grey
            6:       send_pixel(pick_level(), pick_level(), pick_level());
            7:       send_pixel(a, nudge(a), nudge(a));       // near grey
            8:
            begin
                // tie on a random pair of channels, a tie for the maximum when a >= b
                case ($urandom_range(2))
                    0:       send_pixel(a, a, b);
                    1:       send_pixel(b, a, a);
                    default: send_pixel(a, b, a);
                endcase
            end
            9:       send_pixel(FS, a[0] ? b : '0, a[1] ? '0 : nudge('0)); // red rail
            default: send_pixel(a, b, c);
        endcase
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words, no idling on either side.
        send_pixel('0, '0, '0);          // black
        send_pixel(FS, FS, FS);          // white
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(FS, '0, '0);          // primaries and secondaries
        send_pixel('0, FS, '0);
        send_pixel('0, '0, FS);
        send_pixel(FS, FS, '0);
        send_pixel('0, FS, FS);
        send_pixel(FS, '0, FS);
        send_pixel(8'd200, 8'd200, 8'd100);  // red/green tie goes to red
        send_pixel(8'd100, 8'd200, 8'd200);  // green/blue tie goes to green
        send_pixel(8'd200, 8'd100, 8'd200);  // red/blue tie goes to red
        send_pixel(FS, '0, 8'd1);            // hue rounds up to a full turn
        send_pixel(FS, 8'd1, 8'd2);
        send_pixel(8'd1, '0, '0);            // tiny chroma near black, saturation pinned
        send_pixel(FS, 8'd254, 8'd254);      // tiny chroma near white
        send_pixel(8'd254, FS, FS);
        send_pixel(8'd127, 8'd128, 8'd127);
        send_pixel(8'h55, 8'hAA, 8'h0F);
        send_pixel(8'hAA, 8'h55, 8'hF0);
        drain();

        // Random phases: free running, sender idling, receiver stalling, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 80; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                send_random_pixel();
            drain();
        end

        // Quiet tail: anything arriving now is unexpected.
        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("pixels sent: %0d, HSL words checked: %0d, over %0d cycles",
                 pixels_sent, checked, cycles);
        $display("phases: directed, free running, sender idle, receiver stalled, mixed");
        if (mismatches == 0 && outstanding == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
